/* src/rff_pkg.sv */
package rff_pkg;

  localparam int DEF_MAX_IN  = 64;
  localparam int DEF_MAX_OUT = 64;
  localparam int DEF_LANES   = 16;

  localparam int VAL_W  = 16;
  localparam int CNT_W  = 7;
  localparam int GAIN_W = 15;
  localparam int ACC_W  = 40;
  localparam int MOD_STEPS = 13;

  localparam logic [CNT_W-1:0]  IN_COUNT_RST  = 7'd64;
  localparam logic [CNT_W-1:0]  OUT_COUNT_RST = 7'd64;
  localparam logic [GAIN_W-1:0] GAIN_RST      = 15'd2896;

  localparam logic [1:0] REG_IN_COUNT  = 2'd0;
  localparam logic [1:0] REG_OUT_COUNT = 2'd1;
  localparam logic [1:0] REG_GAIN      = 2'd2;

  localparam logic [1:0] MODE_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_BIAS   = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [26:0] TWO_PI_Q24     = 27'd105414357;
  localparam logic [26:0] HALF_PI_Q24    = 27'd26353589;
  localparam logic [26:0] QUARTER_PI_Q24 = 27'd13176795;

  localparam logic [31:0] ONE_Q30 = 32'd1073741824;
  localparam logic [31:0] C_2 = 32'd536870912;
  localparam logic [31:0] C_4 = 32'd44739243;
  localparam logic [31:0] C_6 = 32'd1491308;
  localparam logic [31:0] C_8 = 32'd26631;
  localparam logic [31:0] S_3 = 32'd178956971;
  localparam logic [31:0] S_5 = 32'd8947849;
  localparam logic [31:0] S_7 = 32'd213044;
  localparam logic [31:0] S_9 = 32'd2959;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_COS
  } ctl_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MOD,
    CS_FIX,
    CS_FOLD,
    CS_SQ,
    CS_POLY,
    CS_SINF,
    CS_GAIN
  } cos_state_t;

  // control word broadcast to every MAC cell
  typedef struct packed {
    logic                    wr_w;
    logic [11:0]             w_addr;
    logic [5:0]              w_lane;
    logic                    wr_s;
    logic [5:0]              s_k;
    logic [5:0]              s_lane;
    logic signed [VAL_W-1:0] data;
    logic                    run;
    logic                    issue;
    logic [5:0]              rd_k;
    logic [5:0]              row;
    logic [CNT_W-1:0]        n_in;
  } cell_ctl_t;

  // Horner coefficients, innermost first after the seed term
  function automatic logic [31:0] poly_coef(input logic use_sin, input logic [1:0] k);
    logic [31:0] c;
    case (k)
      2'd0:    c = use_sin ? S_7 : C_6;
      2'd1:    c = use_sin ? S_5 : C_4;
      2'd2:    c = use_sin ? S_3 : C_2;
      default: c = ONE_Q30;
    endcase
    return c;
  endfunction

endpackage

/* src/rff_cell.sv */
module rff_cell #(
  parameter int LANE  = 0,
  parameter int LANES = rff_pkg::DEF_LANES,
  parameter int KD    = 4,
  parameter int ROWS  = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rff_pkg::cell_ctl_t              ctl,
  input  logic signed [rff_pkg::ACC_W-1:0] chain_in,
  output logic signed [rff_pkg::ACC_W-1:0] chain_out
);

  localparam int WDEPTH = ROWS * KD;
  localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int SAW = (KD > 1) ? $clog2(KD) : 1;

  logic signed [rff_pkg::VAL_W-1:0] wmem [WDEPTH];
  logic signed [rff_pkg::VAL_W-1:0] smem [KD];
  logic signed [rff_pkg::VAL_W-1:0] w_q;
  logic signed [rff_pkg::VAL_W-1:0] s_q;
  logic signed [31:0]               prod;
  logic signed [rff_pkg::ACC_W-1:0] acc;
  logic                             rdv;
  logic                             prodv;
  logic [WAW-1:0]                   raddr;
  logic [12:0]                      col;

  assign raddr = WAW'(32'(ctl.row) * KD + 32'(ctl.rd_k));
  assign col   = 13'(ctl.rd_k) * 13'(LANES) + 13'(LANE);

  // store weights and sample words of this lane
  always_ff @(posedge clk) begin
    if (ctl.wr_w && ctl.w_lane == 6'(LANE)) begin
      wmem[ctl.w_addr[WAW-1:0]] <= ctl.data;
    end
    if (ctl.wr_s && ctl.s_lane == 6'(LANE)) begin
      smem[ctl.s_k[SAW-1:0]] <= ctl.data;
    end
    w_q <= wmem[raddr];
    s_q <= smem[ctl.rd_k[SAW-1:0]];
  end

  // mark reads of columns inside the vector
  always_ff @(posedge clk) begin
    if (rst) begin
      rdv   <= 1'b0;
      prodv <= 1'b0;
    end else begin
      rdv   <= ctl.issue && (col < 13'(ctl.n_in));
      prodv <= rdv;
    end
  end

  // multiply, accumulate, hand the partial sum down the row
  always_ff @(posedge clk) begin
    prod <= rdv ? w_q * s_q : 32'sd0;
    if (!ctl.run) begin
      acc <= '0;
    end else if (prodv) begin
      acc <= acc + rff_pkg::ACC_W'(prod);
    end
    chain_out <= chain_in + acc;
  end

endmodule

/* src/rff_cos.sv */
module rff_cos (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  logic signed [rff_pkg::ACC_W-1:0]  phase,
  input  logic [rff_pkg::GAIN_W-1:0]        gain,
  output logic                             done,
  output logic signed [15:0]               feature
);

  rff_pkg::cos_state_t state, state_next;

  logic [rff_pkg::ACC_W-1:0] rem;
  logic                      negp;
  logic [3:0]                step;
  logic [31:0]               ang;
  logic [31:0]               x2;
  logic [31:0]               t;
  logic                      use_sin;
  logic                      negf;
  logic [1:0]                k;

  logic [53:0] sh;
  logic        ge;
  logic [26:0] rr;
  logic [26:0] f;
  logic [1:0]  q;
  logic [63:0] mul_x2t;
  logic [63:0] mul_aa;
  logic [63:0] mul_at;
  logic [46:0] gprod;
  logic [16:0] mag;
  logic signed [15:0] fval;

  // shared arithmetic of the sequencer
  always_comb begin
    sh      = 54'(rff_pkg::TWO_PI_Q24) << step;
    ge      = 54'(rem) >= sh;
    rr      = (negp && rem != '0) ? rff_pkg::TWO_PI_Q24 - rem[26:0] : rem[26:0];
    if (rem[26:0] >= 27'(3 * rff_pkg::HALF_PI_Q24)) begin
      q = 2'd3;
      f = rem[26:0] - 27'(3 * rff_pkg::HALF_PI_Q24);
    end else if (rem[26:0] >= 27'(2 * rff_pkg::HALF_PI_Q24)) begin
      q = 2'd2;
      f = rem[26:0] - 27'(2 * rff_pkg::HALF_PI_Q24);
    end else if (rem[26:0] >= rff_pkg::HALF_PI_Q24) begin
      q = 2'd1;
      f = rem[26:0] - rff_pkg::HALF_PI_Q24;
    end else begin
      q = 2'd0;
      f = rem[26:0];
    end
    mul_x2t = 64'(x2) * 64'(t);
    mul_aa  = 64'(ang) * 64'(ang);
    mul_at  = 64'(ang) * 64'(t);
    gprod   = 47'(gain) * 47'(t) + 47'(1 << 29);
    mag     = gprod[46:30];
    if (negf) begin
      fval = (mag > 17'd32768) ? -16'sd32768 : -$signed(mag[15:0]);
    end else begin
      fval = (mag > 17'd32767) ? 16'sd32767 : $signed(mag[15:0]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rff_pkg::CS_IDLE: if (go) state_next = rff_pkg::CS_MOD;
      rff_pkg::CS_MOD:  if (step == 4'd0) state_next = rff_pkg::CS_FIX;
      rff_pkg::CS_FIX:  state_next = rff_pkg::CS_FOLD;
      rff_pkg::CS_FOLD: state_next = rff_pkg::CS_SQ;
      rff_pkg::CS_SQ:   state_next = rff_pkg::CS_POLY;
      rff_pkg::CS_POLY: begin
        if (k == 2'd3) state_next = use_sin ? rff_pkg::CS_SINF : rff_pkg::CS_GAIN;
      end
      rff_pkg::CS_SINF: state_next = rff_pkg::CS_GAIN;
      rff_pkg::CS_GAIN: state_next = rff_pkg::CS_IDLE;
      default:          state_next = rff_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rff_pkg::CS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == rff_pkg::CS_GAIN);
    end
  end

  // datapath: a subtract, a multiply or both in each step
  always_ff @(posedge clk) begin
    case (state)
      rff_pkg::CS_IDLE: begin
        negp <= phase[rff_pkg::ACC_W-1];
        rem  <= phase[rff_pkg::ACC_W-1] ? rff_pkg::ACC_W'(-phase) : rff_pkg::ACC_W'(phase);
        step <= 4'(rff_pkg::MOD_STEPS - 1);
      end
      rff_pkg::CS_MOD: begin
        if (ge) rem <= rem - sh[rff_pkg::ACC_W-1:0];
        step <= step - 4'd1;
      end
      rff_pkg::CS_FIX: rem <= rff_pkg::ACC_W'(rr);
      rff_pkg::CS_FOLD: begin
        negf <= (q == 2'd1) || (q == 2'd2);
        if (f > rff_pkg::QUARTER_PI_Q24) begin
          ang     <= 32'(rff_pkg::HALF_PI_Q24 - f) << 6;
          use_sin <= ~q[0];
        end else begin
          ang     <= 32'(f) << 6;
          use_sin <= q[0];
        end
      end
      rff_pkg::CS_SQ: begin
        x2 <= mul_aa[61:30];
        t  <= use_sin ? rff_pkg::S_9 : rff_pkg::C_8;
        k  <= 2'd0;
      end
      rff_pkg::CS_POLY: begin
        t <= rff_pkg::poly_coef(use_sin, k) - mul_x2t[61:30];
        k <= k + 2'd1;
      end
      rff_pkg::CS_SINF: t <= mul_at[61:30];
      rff_pkg::CS_GAIN: feature <= fval;
      default: ;
    endcase
  end

endmodule

/* src/random_fourier_feature_projector.sv */
// Each load or sample word is one accepted start; start is taken whenever busy is low.
// After the final sample word the features are computed one at a time, each in turn by
// KD reads per MAC cell, KD = ceil(min(MAX_IN,64)/LANES), the ripple of the sum down the
// cell row, and the shared sequential cosine unit.
// Features leave one per strobe and cannot be stalled by the receiver.
// Synchronous reset clears control and sets config defaults; stores and result are not reset.
module random_fourier_feature_projector #(
  parameter int MAX_IN  = rff_pkg::DEF_MAX_IN,
  parameter int MAX_OUT = rff_pkg::DEF_MAX_OUT,
  parameter int LANES   = rff_pkg::DEF_LANES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        mode,
  input  logic [5:0]                        row,
  input  logic [5:0]                        col,
  input  logic signed [rff_pkg::VAL_W-1:0]  value,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [rff_pkg::GAIN_W-1:0]        cfg_data,
  output logic                              feature_valid,
  output logic [5:0]                        feature_index,
  output logic signed [15:0]                feature,
  output logic                              last
);

  localparam int NIN  = (MAX_IN < 64) ? MAX_IN : 64;
  localparam int NOUT = (MAX_OUT < 64) ? MAX_OUT : 64;
  localparam int KD   = (NIN + LANES - 1) / LANES;
  localparam int BAW  = (NOUT > 1) ? $clog2(NOUT) : 1;

  rff_pkg::ctl_state_t state, state_next;

  logic [rff_pkg::CNT_W-1:0]  in_count;
  logic [rff_pkg::CNT_W-1:0]  out_count;
  logic [rff_pkg::GAIN_W-1:0] gain;
  logic [rff_pkg::CNT_W-1:0]  element_count;
  logic [rff_pkg::CNT_W-1:0]  cnt_inc;
  logic [rff_pkg::CNT_W-1:0]  n_in;
  logic [rff_pkg::CNT_W-1:0]  n_out;
  logic [5:0]                 d;
  logic [5:0]                 k;
  logic [6:0]                 drain;
  logic                       accept;
  logic                       vec_done;
  logic                       cos_go;
  logic                       cos_done;
  logic signed [15:0]         cos_feature;
  logic signed [rff_pkg::VAL_W-1:0] bias_mem [NOUT];
  logic signed [rff_pkg::VAL_W-1:0] bias_q;
  logic signed [rff_pkg::ACC_W-1:0] chain [LANES+1];
  rff_pkg::cell_ctl_t         ctl;
  logic [5:0]                 w_k;
  logic [5:0]                 w_ln;
  logic [5:0]                 s_kk;
  logic [5:0]                 s_ln;

  assign busy    = (state != rff_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign cnt_inc = element_count + 7'd1;
  assign n_in    = (in_count == '0) ? 7'd1 : ((in_count > 7'(NIN)) ? 7'(NIN) : in_count);
  assign n_out   = (out_count == '0) ? 7'd1 : ((out_count > 7'(NOUT)) ? 7'(NOUT) : out_count);
  assign vec_done = accept && mode == rff_pkg::MODE_SAMPLE && cnt_inc >= n_in;
  assign cos_go  = (state == rff_pkg::ST_DRAIN) && (drain == 7'(LANES + 4));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= rff_pkg::IN_COUNT_RST;
      out_count <= rff_pkg::OUT_COUNT_RST;
      gain      <= rff_pkg::GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rff_pkg::REG_IN_COUNT:  in_count  <= cfg_data[rff_pkg::CNT_W-1:0];
        rff_pkg::REG_OUT_COUNT: out_count <= cfg_data[rff_pkg::CNT_W-1:0];
        rff_pkg::REG_GAIN:      gain      <= cfg_data;
        default: ;
      endcase
    end
  end

  // bias store
  always_ff @(posedge clk) begin
    if (accept && mode == rff_pkg::MODE_BIAS && 7'(row) < 7'(NOUT)) begin
      bias_mem[row[BAW-1:0]] <= value;
    end
    bias_q <= bias_mem[d[BAW-1:0]];
  end

  // split column and element index into cell slot and lane by lookup
  always_comb begin
    w_k  = '0;
    w_ln = '0;
    s_kk = '0;
    s_ln = '0;
    for (int c = 0; c < 64; c++) begin
      if (col == 6'(c)) begin
        w_k  = 6'(c / LANES);
        w_ln = 6'(c % LANES);
      end
      if (element_count[5:0] == 6'(c)) begin
        s_kk = 6'(c / LANES);
        s_ln = 6'(c % LANES);
      end
    end
  end

  // control word for the cell row
  always_comb begin
    ctl.wr_w   = accept && mode == rff_pkg::MODE_WEIGHT &&
                 7'(row) < 7'(NOUT) && 7'(col) < 7'(NIN);
    ctl.w_addr = 12'(32'(row) * KD + 32'(w_k));
    ctl.w_lane = w_ln;
    ctl.wr_s   = accept && mode == rff_pkg::MODE_SAMPLE;
    ctl.s_k    = s_kk;
    ctl.s_lane = s_ln;
    ctl.data   = value;
    ctl.run    = (state == rff_pkg::ST_MAC) || (state == rff_pkg::ST_DRAIN);
    ctl.issue  = (state == rff_pkg::ST_MAC);
    ctl.rd_k   = k;
    ctl.row    = d;
    ctl.n_in   = n_in;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rff_pkg::ST_IDLE:  if (vec_done) state_next = rff_pkg::ST_MAC;
      rff_pkg::ST_MAC:   if (k == 6'(KD - 1)) state_next = rff_pkg::ST_DRAIN;
      rff_pkg::ST_DRAIN: if (cos_go) state_next = rff_pkg::ST_COS;
      rff_pkg::ST_COS: begin
        if (cos_done) begin
          state_next = (7'(d) + 7'd1 == n_out) ? rff_pkg::ST_IDLE : rff_pkg::ST_MAC;
        end
      end
      default: state_next = rff_pkg::ST_IDLE;
    endcase
  end

  // sequencer counters and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rff_pkg::ST_IDLE;
      element_count <= '0;
      d             <= '0;
      k             <= '0;
      drain         <= '0;
      feature_valid <= 1'b0;
    end else begin
      state         <= state_next;
      feature_valid <= cos_done;
      if (accept && mode == rff_pkg::MODE_SAMPLE) begin
        element_count <= vec_done ? '0 : cnt_inc;
      end
      if (vec_done) d <= '0;
      else if (state == rff_pkg::ST_COS && cos_done) d <= d + 6'd1;
      if (state == rff_pkg::ST_MAC) k <= k + 6'd1;
      else k <= '0;
      if (state == rff_pkg::ST_DRAIN) drain <= drain + 7'd1;
      else drain <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cos_done) begin
      feature_index <= d;
      feature       <= cos_feature;
      last          <= (7'(d) + 7'd1 == n_out);
    end
  end

  // row of MAC cells; bias enters at the head
  assign chain[0] = rff_pkg::ACC_W'(bias_q) <<< 12;

  for (genvar j = 0; j < LANES; j++) begin : g_cell
    rff_cell #(
      .LANE  (j),
      .LANES (LANES),
      .KD    (KD),
      .ROWS  (NOUT)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .chain_in  (chain[j]),
      .chain_out (chain[j+1])
    );
  end

  rff_cos u_cos (
    .clk     (clk),
    .rst     (rst),
    .go      (cos_go),
    .phase   (chain[LANES]),
    .gain    (gain),
    .done    (cos_done),
    .feature (cos_feature)
  );

endmodule

/* src/rff_check.sv */
module rff_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       feature_valid,
  input logic       last
);

  // busy only rises after a taken start
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // features are spaced apart
  a_spaced: assert property (@(posedge clk) disable iff (rst)
    feature_valid |=> !feature_valid)
    else $error("back to back feature words");

  // more features follow while busy
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    feature_valid && !last |-> busy)
    else $error("idle before final feature");

  // final feature frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    feature_valid && last |-> !busy)
    else $error("still busy on final feature");

endmodule

bind random_fourier_feature_projector rff_check u_rff_check (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .feature_valid (feature_valid),
  .last          (last)
);
